FILE: hdl/utf8_cyrillic_lowercase_filter_top_assert.svh
// ----------------------------------------------------------------------------
// utf8 cyrillic lowercase filter assertion macros
// clocked property checks shared by the rtl; UCLF_ASSERT is disabled while in reset
// ----------------------------------------------------------------------------
`ifndef UTF8_CYRILLIC_LOWERCASE_FILTER_TOP_ASSERT_SVH
`define UTF8_CYRILLIC_LOWERCASE_FILTER_TOP_ASSERT_SVH

// implication check on the rising clock edge, off during reset
`define UCLF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same check, also evaluated while reset is held
`define UCLF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/uclf_pkg.sv
// ----------------------------------------------------------------------------
// uclf_pkg
// shared types, code point constants and helpers of the cyrillic filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uclf_pkg;

    // code point as assembled from one or two input bytes
    localparam int CP_W = 11;
    typedef logic [CP_W-1:0] t_cp;

    localparam t_cp CP_CAP_FIRST = 11'h410;
    localparam t_cp CP_CAP_LAST  = 11'h42F;
    localparam t_cp CP_CAP_YO    = 11'h401;
    localparam t_cp CP_LOW_YO    = 11'h451;
    localparam t_cp CP_LOW_FIRST = 11'h430;
    localparam t_cp CP_LOW_LAST  = 11'h44F;
    localparam t_cp CP_SPACE     = 11'h020;
    localparam t_cp CP_PERIOD    = 11'h02E;
    localparam t_cp CP_COMMA     = 11'h02C;
    localparam t_cp CP_EXCL      = 11'h021;
    localparam t_cp CP_QUEST     = 11'h03F;
    localparam t_cp CP_ASCII_MAX = 11'h07F;
    localparam t_cp CP_CASE_OFS  = 11'h020;

    localparam logic [7:0] LEAD_MARK = 8'hC0;
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [2:0] LEAD_TAG  = 3'b110;

    // default depth of the queue between decoder and encoder
    localparam int QUEUE_DEPTH = 4;

    // read side of the code point queue
    typedef struct packed {
        logic valid;
        t_cp  cp;
    } t_q_rd;

    // fold capitals and yo to lower case
    function automatic t_cp fold_cp(input t_cp cp);
        t_cp res;
        res = cp;
        if (cp >= CP_CAP_FIRST && cp <= CP_CAP_LAST) begin
            res = cp + CP_CASE_OFS;
        end else if (cp == CP_CAP_YO) begin
            res = CP_LOW_YO;
        end
        return res;
    endfunction

    // set of code points that are passed on
    function automatic logic cp_is_kept(input t_cp cp);
        return (cp >= CP_LOW_FIRST && cp <= CP_LOW_LAST) || cp == CP_LOW_YO ||
               cp == CP_SPACE || cp == CP_PERIOD || cp == CP_COMMA ||
               cp == CP_EXCL || cp == CP_QUEST;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/uclf_front.sv
// ----------------------------------------------------------------------------
// uclf_front
// byte decoder: joins two-byte sequences, folds case and filters code points
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uclf_front import uclf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,      // [7:0] in_byte
    input  wire logic       i_s_tlast,      // end_of_text
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_cp             o_q_cp,
    output logic            o_lead_pending
);

    logic       r_lead_pending, n_lead_pending;
    logic [4:0] r_lead_bits, n_lead_bits;
    logic       w_accept;
    logic       w_has_cp;
    t_cp        w_raw_cp;
    t_cp        w_cp;

    assign o_s_tready     = !i_q_full;
    assign w_accept       = i_s_tvalid && o_s_tready;
    assign o_lead_pending = r_lead_pending;

    // assemble the code point of this byte
    always_comb begin
        w_has_cp = 1'b0;
        w_raw_cp = '0;
        if (r_lead_pending) begin
            w_has_cp = 1'b1;
            w_raw_cp = {r_lead_bits, i_s_tdata[5:0]};
        end else if (!i_s_tdata[7]) begin
            w_has_cp = 1'b1;
            w_raw_cp = {3'b000, i_s_tdata};
        end
    end

    assign w_cp     = fold_cp(w_raw_cp);
    assign o_q_cp   = w_cp;
    assign o_q_push = w_accept && w_has_cp && cp_is_kept(w_cp);

    // pending lead: any accepted byte consumes it, a lead on end of text is dropped
    always_comb begin
        n_lead_pending = r_lead_pending;
        n_lead_bits    = r_lead_bits;
        if (w_accept) begin
            if (r_lead_pending) begin
                n_lead_pending = 1'b0;
                n_lead_bits    = '0;
            end else if (i_s_tdata[7:5] == LEAD_TAG && !i_s_tlast) begin
                n_lead_pending = 1'b1;
                n_lead_bits    = i_s_tdata[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_lead_bits    <= '0;
        end else begin
            r_lead_pending <= n_lead_pending;
            r_lead_bits    <= n_lead_bits;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/uclf_queue.sv
// ----------------------------------------------------------------------------
// uclf_queue
// short fifo of kept code points between decoder and encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uclf_queue import uclf_pkg::*; #(
    parameter int Depth = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cp  i_push_cp,
    output logic      o_full,
    output t_q_rd     o_rd,
    input  wire logic i_pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_cp             r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            w_push, w_pop;

    assign o_full   = (r_count == CntW'(Depth));
    assign o_rd     = '{valid: (r_count != '0), cp: r_mem[r_rd_ptr]};
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && o_rd.valid;

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cp;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/uclf_back.sv
// ----------------------------------------------------------------------------
// uclf_back
// utf-8 encoder: turns queued code points into one or two output bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uclf_back import uclf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_q_rd i_rd,
    output logic      o_pop,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic      o_m_tlast      // last_of_run
);

    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_sec_pend, n_sec_pend;
    logic [7:0] r_sec_byte, n_sec_byte;
    logic       w_load;

    // output register is free or being emptied this cycle
    assign w_load = !r_valid || i_m_tready;
    assign o_pop  = w_load && !r_sec_pend && i_rd.valid;

    always_comb begin
        n_valid    = r_valid;
        n_byte     = r_byte;
        n_last     = r_last;
        n_sec_pend = r_sec_pend;
        n_sec_byte = r_sec_byte;
        if (w_load) begin
            if (r_sec_pend) begin
                // continuation byte of a two-byte item
                n_valid    = 1'b1;
                n_byte     = r_sec_byte;
                n_last     = 1'b1;
                n_sec_pend = 1'b0;
            end else if (i_rd.valid) begin
                n_valid = 1'b1;
                if (i_rd.cp <= CP_ASCII_MAX) begin
                    n_byte = i_rd.cp[7:0];
                    n_last = 1'b1;
                end else begin
                    n_byte     = LEAD_MARK | {3'b000, i_rd.cp[10:6]};
                    n_last     = 1'b0;
                    n_sec_pend = 1'b1;
                    n_sec_byte = CONT_MARK | {2'b00, i_rd.cp[5:0]};
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sec_pend <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_sec_pend <= n_sec_pend;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_sec_byte <= n_sec_byte;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;

endmodule

`default_nettype wire

FILE: hdl/utf8_cyrillic_lowercase_filter_top.sv
// ----------------------------------------------------------------------------
// utf8_cyrillic_lowercase_filter_top
// utf-8 byte filter keeping lower-case cyrillic and a few punctuation marks
// ----------------------------------------------------------------------------
// channel   dir  tdata          tuser  tlast
// s_*       in   [7:0] in_byte  -      end_of_text
// m_*       out  [7:0] out_byte -      last_of_run
//
// one input byte is taken per cycle while the code point queue has room.
// each kept code point leaves as one or two bytes, one byte per cycle while
// the output is taken, from the output register; the code point is queued
// first and its first byte is then loaded into the output register.
// the decoder and encoder are parted by a Depth-entry queue, so an output
// stall backs up into the input only once the queue is full.
// reset is synchronous active low and clears the lead, queue and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_cyrillic_lowercase_filter_top import uclf_pkg::*; #(
    parameter int Depth = QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] in_byte
    input  wire logic       s_tlast,    // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] out_byte
    output logic            m_tlast     // last_of_run
);

`include "utf8_cyrillic_lowercase_filter_top_assert.svh"

    logic  w_q_full;
    logic  w_q_push;
    t_cp   w_q_cp;
    t_q_rd w_q_rd;
    logic  w_q_pop;
    logic  w_lead_pending;
    logic  w_m_take;
    logic  w_m_lead;
    logic  w_m_cont;
    logic  w_lead_in;

    // decoder
    uclf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .o_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tlast      (s_tlast),
        .i_q_full       (w_q_full),
        .o_q_push       (w_q_push),
        .o_q_cp         (w_q_cp),
        .o_lead_pending (w_lead_pending)
    );

    // code point queue
    uclf_queue #(
        .Depth (Depth)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_q_push),
        .i_push_cp (w_q_cp),
        .o_full    (w_q_full),
        .o_rd      (w_q_rd),
        .i_pop     (w_q_pop)
    );

    // encoder
    uclf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (w_q_rd),
        .o_pop      (w_q_pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    // terms used by the checks
    assign w_m_take  = m_tvalid && m_tready;
    assign w_m_lead  = m_tvalid && !m_tlast;
    assign w_m_cont  = m_tvalid && m_tlast && (m_tdata[7:6] == CONT_MARK[7:6]);
    assign w_lead_in = s_tvalid && s_tready && !w_lead_pending &&
                       (s_tdata[7:5] == LEAD_TAG) && !s_tlast;

    // checks
    `UCLF_ASSERT(a_no_push_full, w_q_push |-> !w_q_full, "push into full queue")
    `UCLF_ASSERT(a_lead_shape, w_m_lead |-> (m_tdata[7:5] == LEAD_TAG), "bad lead byte")
    `UCLF_ASSERT(a_cont_follows, (w_m_take && !m_tlast) |=> w_m_cont, "missing continuation")
    `UCLF_ASSERT(a_lead_held, w_lead_in |=> w_lead_pending, "lead not held")

endmodule

`default_nettype wire

FILE: tb/utf8_cyrillic_lowercase_filter_checker.sv
// ----------------------------------------------------------------------------
// utf8_cyrillic_lowercase_filter_checker
// watches both stream channels of the cyrillic filter, predicts the output
// bytes of every accepted input item and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_cyrillic_lowercase_filter_checker import uclf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  wire logic       i_s_tlast,    // end_of_text
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,    // [7:0] out_byte
    input  wire logic       i_m_tlast,    // last_of_run
    output int              o_fail_count,
    output int              o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    // decoder state of the prediction
    logic        lead_held;
    logic [4:0]  lead_bits;
    t_out_byte   folded_bytes_q[$];
    int          fail_cnt;

    assign o_fail_count = fail_cnt;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_cnt++;
    endtask

    // decode one input byte, fold case and queue the bytes it re-encodes to
    task automatic push_folded_bytes(input logic [7:0] b, input logic eot);
        t_cp  cp;
        logic have_cp;
        t_out_byte ob;
        have_cp = 1'b1;
        cp      = '0;
        if (lead_held) begin
            cp        = {lead_bits, b[5:0]};
            lead_held = 1'b0;
            lead_bits = '0;
        end else if (!b[7]) begin
            cp = t_cp'(b);
        end else if (b[7:5] == LEAD_TAG) begin
            // a lead on the last byte of a text is dropped
            if (!eot) begin
                lead_held = 1'b1;
                lead_bits = b[4:0];
            end
            have_cp = 1'b0;
        end else begin
            have_cp = 1'b0;
        end
        if (have_cp) begin
            if (cp >= CP_CAP_FIRST && cp <= CP_CAP_LAST) begin
                cp = cp + (CP_LOW_FIRST - CP_CAP_FIRST);
            end else if (cp == CP_CAP_YO) begin
                cp = CP_LOW_YO;
            end
            if (cp inside {[CP_LOW_FIRST:CP_LOW_LAST], CP_LOW_YO, CP_SPACE, CP_PERIOD,
                           CP_COMMA, CP_EXCL, CP_QUEST}) begin
                if (cp <= CP_ASCII_MAX) begin
                    ob.data = cp[7:0];
                    ob.last = 1'b1;
                    folded_bytes_q.insert(folded_bytes_q.size(), ob);
                end else begin
                    ob.data = LEAD_MARK | {3'b000, cp[10:6]};
                    ob.last = 1'b0;
                    folded_bytes_q.insert(folded_bytes_q.size(), ob);
                    ob.data = CONT_MARK | {2'b00, cp[5:0]};
                    ob.last = 1'b1;
                    folded_bytes_q.insert(folded_bytes_q.size(), ob);
                end
            end
        end
    endtask

    // compare output items first, then predict from the input item
    always @(posedge i_clk) begin
        t_out_byte want;
        if (!i_rst_n) begin
            lead_held = 1'b0;
            lead_bits = '0;
            folded_bytes_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (folded_bytes_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                              i_m_tdata, i_m_tlast));
                end else begin
                    want = folded_bytes_q.pop_front();
                    if (i_m_tdata !== want.data) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  i_m_tdata, want.data));
                    end
                    if (i_m_tlast !== want.last) begin
                        report_mismatch($sformatf("last_of_run %0b, expected %0b (byte %02h)",
                                                  i_m_tlast, want.last, want.data));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                push_folded_bytes(i_s_tdata, i_s_tlast);
            end
        end
        o_pending <= folded_bytes_q.size();
    end

endmodule

FILE: tb/utf8_cyrillic_lowercase_filter_top_tb.sv
// ----------------------------------------------------------------------------
// utf8_cyrillic_lowercase_filter_top_tb
// drives utf-8 byte streams into the cyrillic filter with random gaps and
// output stalls; a checker beside the block predicts and compares the bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_cyrillic_lowercase_filter_top_tb import uclf_pkg::*; ();

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 650;
    localparam int MAX_GAP      = 14;
    localparam int N_DIRECTED   = 27;

    // directed bytes as {end_of_text, in_byte}
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        9'h020, 9'h02E, 9'h02C, 9'h021, 9'h13F,   // kept punctuation
        9'h041, 9'h07F,                           // ascii outside the kept set
        9'h0D0, 9'h090, 9'h0D0, 9'h0AF,           // capital a, capital ya
        9'h0D0, 9'h081, 9'h0D1, 9'h091,           // capital yo, lower yo
        9'h0D1, 9'h18F,                           // lower ya, end on continuation
        9'h0C0, 9'h0A0,                           // overlong space
        9'h0D0, 9'h041,                           // lead then ascii, joined anyway
        9'h1D0,                                   // lead on the last byte
        9'h080, 9'h0E0, 9'h0FF,                   // stray bytes
        9'h0D0, 9'h0D0                            // lead then lead
    };

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    int   rx_stall  = 0;
    int   rx_gap;
    logic tx_quiet  = 1'b0;
    logic rx_quiet  = 1'b0;

    utf8_cyrillic_lowercase_filter_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    utf8_cyrillic_lowercase_filter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side: random stall after each accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else if (m_tvalid && m_tready) begin
            rx_gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            m_tready <= (rx_gap == 0);
            rx_stall <= rx_gap;
        end else if (!m_tready) begin
            if (rx_stall <= 1) begin
                m_tready <= 1'b1;
            end
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
            end
        end
    end

    // present one input item after a random gap and wait for its handshake
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_two_byte(input t_cp cp, input logic eot);
        send_byte(LEAD_MARK | {3'b000, cp[10:6]}, 1'b0);
        send_byte(CONT_MARK | {2'b00, cp[5:0]}, eot);
    endtask

    initial begin
        int   useful;
        int   pick;
        int   iter;
        logic eot;
        t_cp  cp;
        logic [7:0] b;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        for (int k = 0; k < N_DIRECTED; k++) begin
            send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
        end

        // random part: mostly well-formed cyrillic and punctuation, some noise
        useful = 0;
        iter   = 0;
        while (useful < RANDOM_ITEMS) begin
            if (iter % 40 == 0) begin
                tx_quiet <= ($urandom_range(0, 3) == 0);
                rx_quiet <= ($urandom_range(0, 3) == 0);
            end
            iter++;
            pick = $urandom_range(0, 9);
            eot  = ($urandom_range(0, 9) == 0);
            if (pick <= 4) begin
                // cyrillic block including capitals, yo and neighbors
                cp = t_cp'($urandom_range(11'h400, 11'h45F));
                send_two_byte(cp, eot);
                useful += 2;
            end else if (pick <= 6) begin
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 4))
                        0:       cp = CP_SPACE;
                        1:       cp = CP_PERIOD;
                        2:       cp = CP_COMMA;
                        3:       cp = CP_EXCL;
                        default: cp = CP_QUEST;
                    endcase
                    b = cp[7:0];
                end else begin
                    b = 8'($urandom_range(0, 127));
                end
                send_byte(b, eot);
                useful++;
            end else if (pick == 7) begin
                // any lead followed by any byte, broken continuations too
                send_byte(8'($urandom_range(8'hC0, 8'hDF)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), eot);
                useful += 2;
            end else if (pick == 8) begin
                // lead on the last byte of a text
                send_byte(8'($urandom_range(8'hC0, 8'hDF)), 1'b1);
                useful++;
            end else begin
                send_byte(8'($urandom_range(0, 255)), eot);
                useful++;
            end
        end
        s_tvalid <= 1'b0;
        rx_quiet <= 1'b0;

        // drain
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
